FILE: rtl/core/dpr_pkg.sv
// Shared types, register indexes and saturation helper for disparity reprojection.
package dpr_pkg;

  localparam logic [2:0] CFG_FOCAL_BASELINE = 3'd0;
  localparam logic [2:0] CFG_INVALID_DEPTH  = 3'd1;
  localparam logic [2:0] CFG_CENTER_X_TWICE = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y_TWICE = 3'd3;
  localparam logic [2:0] CFG_FOCAL_X        = 3'd4;
  localparam logic [2:0] CFG_FOCAL_Y        = 3'd5;
  localparam logic [2:0] CFG_COLOR_STEP     = 3'd6;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [7:0]  disparity;
    logic [7:0]  channel_two;
    logic [7:0]  channel_one;
    logic [7:0]  channel_zero;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [14:0]        point_depth;
    logic [8:0]         quant_two;
    logic [8:0]         quant_one;
    logic [8:0]         quant_zero;
  } point_t;

  function automatic logic [31:0] sat_q8(logic neg, logic [34:0] mag);
    logic [34:0] n;
    logic [31:0] r;
    n = ~mag + 35'd1;
    if (neg) begin
      if (mag > 35'h080000000) r = 32'h80000000;
      else r = n[31:0];
    end else begin
      if (mag > 35'h07FFFFFFF) r = 32'h7FFFFFFF;
      else r = mag[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/disparity_to_point_reprojection.sv
// Top level: disparity to 3-D point reprojection with colour quantization.
//
//  channel   direction  handshake              payload
//  pixel     in         in_valid_i/in_ready_o  dpr_pkg::pixel_t
//  point     out        out_valid_o/out_ready_i dpr_pkg::point_t
//  config    in         cfg_we_i               cfg_index_i, cfg_data_i
//
// One pixel per cycle while the output is not stalled; pipeline of 4 depth/colour divider stages,
// one multiply stage, 5 coordinate divider stages and one output register.
// Pixels with an odd row or column leave the pipeline as bubbles.
// A stalled output freezes every stage; reset clears all valid bits.
module disparity_to_point_reprojection #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dpr_pkg::pixel_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dpr_pkg::point_t out_data_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_index_i,
  input  logic [14:0]     cfg_data_i
);

  localparam int unsigned CW = (COORD_WIDTH < 12) ? COORD_WIDTH : 12;

  logic [14:0] fb_q, inv_q;
  logic [12:0] cx_q, cy_q;
  logic [11:0] fx_q, fy_q;
  logic [7:0]  step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q   <= 15'd350;
      inv_q  <= 15'd35;
      cx_q   <= 13'd1391;
      cy_q   <= 13'd721;
      fx_q   <= 12'd700;
      fy_q   <= 12'd700;
      step_q <= 8'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dpr_pkg::CFG_FOCAL_BASELINE: fb_q   <= cfg_data_i;
        dpr_pkg::CFG_INVALID_DEPTH:  inv_q  <= cfg_data_i;
        dpr_pkg::CFG_CENTER_X_TWICE: cx_q   <= cfg_data_i[12:0];
        dpr_pkg::CFG_CENTER_Y_TWICE: cy_q   <= cfg_data_i[12:0];
        dpr_pkg::CFG_FOCAL_X:        fx_q   <= cfg_data_i[11:0];
        dpr_pkg::CFG_FOCAL_Y:        fy_q   <= cfg_data_i[11:0];
        dpr_pkg::CFG_COLOR_STEP:     step_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic        en;
  logic        out_valid_q;
  dpr_pkg::point_t out_data_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic [11:0] cmask, row_m, col_m;
  logic [13:0] dx, dy, nx, ny;
  logic        sx, sy, v_in, dz;
  logic [12:0] magx, magy;
  logic [7:0]  step_s;
  logic [11:0] fx_s, fy_s;

  assign cmask  = 12'((13'd1 << CW) - 13'd1);
  assign row_m  = in_data_i.pixel_row & cmask;
  assign col_m  = in_data_i.pixel_col & cmask;
  assign v_in   = in_valid_i && !row_m[0] && !col_m[0];
  assign dz     = (in_data_i.disparity == 8'd0);
  assign dx     = {1'b0, col_m, 1'b0} - {1'b0, cx_q};
  assign dy     = {1'b0, row_m, 1'b0} - {1'b0, cy_q};
  assign nx     = ~dx + 14'd1;
  assign ny     = ~dy + 14'd1;
  assign sx     = dx[13];
  assign sy     = dy[13];
  assign magx   = sx ? nx[12:0] : dx[12:0];
  assign magy   = sy ? ny[12:0] : dy[12:0];
  assign step_s = (step_q == 8'd0) ? 8'd1 : step_q;
  assign fx_s   = (fx_q == 12'd0) ? 12'd1 : fx_q;
  assign fy_s   = (fy_q == 12'd0) ? 12'd1 : fy_q;

  logic [14:0] zq;
  logic [7:0]  qc2, qc1, qc0;
  logic        v1, dz1;
  logic [13:0] sidex1, sidey1;

  dpr_div #(.N(15), .M(8), .P(4), .W(1)) u_depth (
    .clk_i, .rst_ni, .en_i(en),
    .dividend_i(fb_q), .divisor_i(in_data_i.disparity), .side_i(v_in),
    .quot_o(zq), .side_o(v1)
  );

  dpr_div #(.N(8), .M(8), .P(4), .W(1)) u_col2 (
    .clk_i, .rst_ni, .en_i(en),
    .dividend_i(in_data_i.channel_two), .divisor_i(step_s), .side_i(dz),
    .quot_o(qc2), .side_o(dz1)
  );

  dpr_div #(.N(8), .M(8), .P(4), .W(14)) u_col1 (
    .clk_i, .rst_ni, .en_i(en),
    .dividend_i(in_data_i.channel_one), .divisor_i(step_s), .side_i({sx, magx}),
    .quot_o(qc1), .side_o(sidex1)
  );

  dpr_div #(.N(8), .M(8), .P(4), .W(14)) u_col0 (
    .clk_i, .rst_ni, .en_i(en),
    .dividend_i(in_data_i.channel_zero), .divisor_i(step_s), .side_i({sy, magy}),
    .quot_o(qc0), .side_o(sidey1)
  );

  logic [14:0] z1;
  logic [15:0] p2, p1, p0;
  logic        v2_q, sx2_q, sy2_q;
  logic [14:0] z2_q;
  logic [27:0] mx2_q, my2_q;
  logic [8:0]  q2_q, q1_q, q0_q;

  assign z1 = dz1 ? inv_q : zq;
  assign p2 = 16'(qc2 * step_s) + {9'd0, step_s[7:1]};
  assign p1 = 16'(qc1 * step_s) + {9'd0, step_s[7:1]};
  assign p0 = 16'(qc0 * step_s) + {9'd0, step_s[7:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z2_q  <= z1;
      sx2_q <= sidex1[13];
      sy2_q <= sidey1[13];
      mx2_q <= 28'(sidex1[12:0] * z1);
      my2_q <= 28'(sidey1[12:0] * z1);
      q2_q  <= p2[8:0];
      q1_q  <= p1[8:0];
      q0_q  <= p0[8:0];
    end
  end

  logic [34:0] qx, qy;
  logic        v3, sx3, sy3;
  logic [14:0] z3;
  logic [8:0]  q2_3, q1_3, q0_3;

  dpr_div #(.N(35), .M(12), .P(5), .W(17)) u_div_x (
    .clk_i, .rst_ni, .en_i(en),
    .dividend_i({mx2_q, 7'd0}), .divisor_i(fx_s), .side_i({v2_q, sx2_q, z2_q}),
    .quot_o(qx), .side_o({v3, sx3, z3})
  );

  dpr_div #(.N(35), .M(12), .P(5), .W(28)) u_div_y (
    .clk_i, .rst_ni, .en_i(en),
    .dividend_i({my2_q, 7'd0}), .divisor_i(fy_s), .side_i({sy2_q, q2_q, q1_q, q0_q}),
    .quot_o(qy), .side_o({sy3, q2_3, q1_3, q0_3})
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.point_x     <= dpr_pkg::sat_q8(sx3, qx);
      out_data_q.point_y     <= dpr_pkg::sat_q8(sy3, qy);
      out_data_q.point_depth <= z3;
      out_data_q.quant_two   <= q2_3;
      out_data_q.quant_one   <= q1_3;
      out_data_q.quant_zero  <= q0_3;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/core/dpr_div.sv
// Pipelined restoring divider with a fixed stage count and a sideband that travels along.
module dpr_div #(
  parameter int unsigned N = 15,
  parameter int unsigned M = 8,
  parameter int unsigned P = 4,
  parameter int unsigned W = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [N-1:0] dividend_i,
  input  logic [M-1:0] divisor_i,
  input  logic [W-1:0] side_i,
  output logic [N-1:0] quot_o,
  output logic [W-1:0] side_o
);

  localparam int unsigned S = (N + P - 1) / P;

  logic [M+N-1:0] acc_q [P];
  logic [M+N-1:0] acc_d [P];
  logic [M-1:0]   div_q [P];
  logic [W-1:0]   side_q [P];
  logic [M+N-1:0] src_acc [P];
  logic [M-1:0]   src_div [P];
  logic [W-1:0]   src_side [P];

  for (genvar p = 0; p < P; p++) begin : g_stage
    if (p == 0) begin : g_first
      assign src_acc[p]  = {{M{1'b0}}, dividend_i};
      assign src_div[p]  = divisor_i;
      assign src_side[p] = side_i;
    end else begin : g_next
      assign src_acc[p]  = acc_q[p-1];
      assign src_div[p]  = div_q[p-1];
      assign src_side[p] = side_q[p-1];
    end

    always_comb begin
      logic [M+N-1:0] a;
      logic [M:0]     top;
      logic           qbit;
      a    = src_acc[p];
      top  = '0;
      qbit = 1'b0;
      for (int k = 0; k < S; k++) begin
        if (p * S + k < N) begin
          top  = a[M+N-1:N-1];
          qbit = 1'b0;
          if (top >= {1'b0, src_div[p]}) begin
            top  = top - {1'b0, src_div[p]};
            qbit = 1'b1;
          end
          a = {top[M-1:0], a[N-2:0], qbit};
        end
      end
      acc_d[p] = a;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[p] <= acc_d[p];
        div_q[p] <= src_div[p];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[p] <= '0;
      end else if (en_i) begin
        side_q[p] <= src_side[p];
      end
    end
  end

  assign quot_o = acc_q[P-1][N-1:0];
  assign side_o = side_q[P-1];

endmodule

FILE: tb/disparity_to_point_reprojection_checker.sv
// Checker: watches pixel, point and config traffic, predicts points and compares them.
module disparity_to_point_reprojection_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  dpr_pkg::pixel_t in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  dpr_pkg::point_t out_data_i,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_index_i,
  input  logic [14:0]     cfg_data_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              point_count_o
);

  logic [14:0]     focal_baseline_q, invalid_depth_q;
  logic [12:0]     center_x_q, center_y_q;
  logic [11:0]     focal_x_q, focal_y_q;
  logic [7:0]      color_step_q;
  dpr_pkg::point_t expected_points[$];

  function automatic logic [31:0] coord_q8(logic [11:0] pos, logic [12:0] c2,
                                           logic [14:0] z, logic [11:0] f);
    longint diff, den, num, q;
    diff = longint'(pos) * 2 - longint'(c2);
    den  = (f == 0) ? 1 : longint'(f);
    num  = diff * longint'(z) * 128;
    q    = num / den;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic logic [8:0] quant_color(logic [7:0] c, logic [7:0] step);
    int s;
    s = (step == 0) ? 1 : int'(step);
    return 9'((int'(c) / s) * s + s / 2);
  endfunction

  function automatic dpr_pkg::point_t project_pixel(dpr_pkg::pixel_t p);
    dpr_pkg::point_t r;
    logic [14:0] z;
    z = (p.disparity == 0) ? invalid_depth_q : 15'(focal_baseline_q / p.disparity);
    r.point_x     = coord_q8(p.pixel_col, center_x_q, z, focal_x_q);
    r.point_y     = coord_q8(p.pixel_row, center_y_q, z, focal_y_q);
    r.point_depth = z;
    r.quant_two   = quant_color(p.channel_two, color_step_q);
    r.quant_one   = quant_color(p.channel_one, color_step_q);
    r.quant_zero  = quant_color(p.channel_zero, color_step_q);
    return r;
  endfunction

  assign pending_o = expected_points.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    dpr_pkg::point_t e;
    if (!rst_ni) begin
      focal_baseline_q <= 15'd350;
      invalid_depth_q  <= 15'd35;
      center_x_q       <= 13'd1391;
      center_y_q       <= 13'd721;
      focal_x_q        <= 12'd700;
      focal_y_q        <= 12'd700;
      color_step_q     <= 8'd64;
      fail_count_o     <= 0;
      point_count_o    <= 0;
      expected_points.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          dpr_pkg::CFG_FOCAL_BASELINE: focal_baseline_q <= cfg_data_i;
          dpr_pkg::CFG_INVALID_DEPTH:  invalid_depth_q  <= cfg_data_i;
          dpr_pkg::CFG_CENTER_X_TWICE: center_x_q       <= cfg_data_i[12:0];
          dpr_pkg::CFG_CENTER_Y_TWICE: center_y_q       <= cfg_data_i[12:0];
          dpr_pkg::CFG_FOCAL_X:        focal_x_q        <= cfg_data_i[11:0];
          dpr_pkg::CFG_FOCAL_Y:        focal_y_q        <= cfg_data_i[11:0];
          dpr_pkg::CFG_COLOR_STEP:     color_step_q     <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i && !in_data_i.pixel_row[0] && !in_data_i.pixel_col[0])
        expected_points.insert(expected_points.size(), project_pixel(in_data_i));
      if (out_valid_i && out_ready_i) begin
        point_count_o <= point_count_o + 1;
        if (expected_points.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected point %h", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_points.pop_front();
          if (e !== out_data_i) begin
            if (fail_count_o < 10) begin
              $display("mismatch: expected x=%0d y=%0d z=%0d q=%0d/%0d/%0d",
                       e.point_x, e.point_y, e.point_depth,
                       e.quant_two, e.quant_one, e.quant_zero);
              $display("          got      x=%0d y=%0d z=%0d q=%0d/%0d/%0d",
                       out_data_i.point_x, out_data_i.point_y, out_data_i.point_depth,
                       out_data_i.quant_two, out_data_i.quant_one, out_data_i.quant_zero);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/disparity_to_point_reprojection_tb.sv
// Testbench top: drives pixels and config writes, applies back-pressure, reports the verdict.
module disparity_to_point_reprojection_tb;

  localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  dpr_pkg::pixel_t in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  dpr_pkg::point_t out_data_o;
  logic            cfg_we_i = 1'b0;
  logic [2:0]      cfg_index_i = '0;
  logic [14:0]     cfg_data_i = '0;
  int              fail_count, pending, point_count;
  int              send_idle_pct = 0, recv_idle_pct = 0;
  int              stall_cycles = 0;
  int              pixel_count = 0;

  disparity_to_point_reprojection DUT (.*);

  disparity_to_point_reprojection_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .point_count_o(point_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [14:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic drain_points();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic send_pixel(dpr_pkg::pixel_t p);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pixel_count++;
  endtask

  function automatic dpr_pkg::pixel_t rand_pixel();
    dpr_pkg::pixel_t p;
    p = dpr_pkg::pixel_t'(56'({$urandom, $urandom}));
    if ($urandom_range(3) != 0) begin
      p.pixel_row[0] = 1'b0;
      p.pixel_col[0] = 1'b0;
    end
    if ($urandom_range(9) == 0) p.disparity = 8'd0;
    return p;
  endfunction

  task automatic rand_config(bit extreme);
    if (extreme) begin
      write_reg(dpr_pkg::CFG_FOCAL_BASELINE, $urandom_range(1) ? 15'h7FFF : 15'd0);
      write_reg(dpr_pkg::CFG_INVALID_DEPTH, $urandom_range(1) ? 15'h7FFF : 15'd0);
      write_reg(dpr_pkg::CFG_CENTER_X_TWICE, $urandom_range(1) ? 15'h1FFF : 15'd0);
      write_reg(dpr_pkg::CFG_CENTER_Y_TWICE, $urandom_range(1) ? 15'h1FFF : 15'd0);
      write_reg(dpr_pkg::CFG_FOCAL_X, $urandom_range(1) ? 15'hFFF : 15'd0);
      write_reg(dpr_pkg::CFG_FOCAL_Y, $urandom_range(1) ? 15'd1 : 15'd0);
      write_reg(dpr_pkg::CFG_COLOR_STEP, $urandom_range(1) ? 15'hFF : 15'd0);
    end else begin
      write_reg(dpr_pkg::CFG_FOCAL_BASELINE, 15'($urandom));
      write_reg(dpr_pkg::CFG_INVALID_DEPTH, 15'($urandom));
      write_reg(dpr_pkg::CFG_CENTER_X_TWICE, 15'($urandom_range(8191)));
      write_reg(dpr_pkg::CFG_CENTER_Y_TWICE, 15'($urandom_range(8191)));
      write_reg(dpr_pkg::CFG_FOCAL_X, 15'($urandom_range(4095)));
      write_reg(dpr_pkg::CFG_FOCAL_Y, 15'($urandom_range(4095)));
      write_reg(dpr_pkg::CFG_COLOR_STEP, 15'($urandom_range(255)));
    end
    write_reg(CFG_UNUSED_INDEX, 15'($urandom));
  endtask

  initial begin
    dpr_pkg::pixel_t p;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_pixel('{12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{12'd4094, 12'd4094, 8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel('{12'd1, 12'd2, 8'd10, 8'd1, 8'd2, 8'd3});
    send_pixel('{12'd2, 12'd1, 8'd10, 8'd1, 8'd2, 8'd3});
    send_pixel('{12'd4095, 12'd4095, 8'd1, 8'd0, 8'd0, 8'd0});
    send_pixel('{12'd700, 12'd1390, 8'd1, 8'd63, 8'd64, 8'd127});
    send_pixel('{12'd2730, 12'd1364, 8'd170, 8'd170, 8'd85, 8'd170});
    drain_points();
    rand_config(1'b1);
    send_pixel('{12'd0, 12'd4094, 8'd1, 8'd255, 8'd254, 8'd0});
    send_pixel('{12'd4094, 12'd0, 8'd0, 8'd128, 8'd1, 8'd77});
    send_pixel('{12'd4094, 12'd4094, 8'd2, 8'd200, 8'd10, 8'd99});
    drain_points();
    write_reg(dpr_pkg::CFG_FOCAL_X, 15'd0);
    write_reg(dpr_pkg::CFG_FOCAL_Y, 15'd0);
    write_reg(dpr_pkg::CFG_COLOR_STEP, 15'd0);
    write_reg(dpr_pkg::CFG_FOCAL_BASELINE, 15'd0);
    send_pixel('{12'd4094, 12'd0, 8'd5, 8'd33, 8'd200, 8'd7});
    send_pixel('{12'd0, 12'd4094, 8'd0, 8'd33, 8'd200, 8'd7});

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 36 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        drain_points();
        rand_config(seg == 3);
        for (int k = 0; k < 128; k++) begin
          p = rand_pixel();
          send_pixel(p);
        end
      end
    end
    drain_points();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 20; k++) send_pixel(rand_pixel());
    drain_points();

    $display("Sent %0d pixels, checked %0d points over directed, extreme and random settings.",
             pixel_count, point_count);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/dpr_pkg.sv
rtl/core/dpr_div.sv
rtl/core/disparity_to_point_reprojection.sv
tb/disparity_to_point_reprojection_checker.sv
tb/disparity_to_point_reprojection_tb.sv
